// ===== rtl/jet_pkg.sv =====
package jet_pkg;

    localparam int COORD_WIDTH    = 12;
    localparam int ITER_WIDTH     = 16;
    localparam int FRAC_BITS      = 28;
    localparam int CMP_WIDTH      = 32;
    localparam int STEP_WIDTH     = 31;
    localparam int PROD_WIDTH     = 2 * CMP_WIDTH;
    localparam int MAP_WIDTH      = COORD_WIDTH + STEP_WIDTH;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int BYTE_WIDTH     = 8;
    localparam int IN_TDATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS       = ITER_WIDTH + 3 * BYTE_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    localparam int ESC_EXP = 2 * FRAC_BITS + 2;
    localparam logic ESC_ON = (ESC_EXP < PROD_WIDTH);
    localparam logic [PROD_WIDTH-1:0] ESC_LIMIT =
        PROD_WIDTH'(1) << (ESC_EXP % PROD_WIDTH);

    localparam logic [BYTE_WIDTH-1:0] BYTE_FULL = 8'hFF;
    localparam logic [BYTE_WIDTH-1:0] BYTE_ZERO = 8'h00;

    localparam logic signed [PROD_WIDTH-1:0] SAT_HI = PROD_WIDTH'(64'sd2147483647);
    localparam logic signed [PROD_WIDTH-1:0] SAT_LO = -PROD_WIDTH'(64'sd2147483648);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_CONST_REAL  = 3'd0,
        REG_CONST_IMAG  = 3'd1,
        REG_ORIGIN_REAL = 3'd2,
        REG_ORIGIN_IMAG = 3'd3,
        REG_STEP_REAL   = 3'd4,
        REG_STEP_IMAG   = 3'd5,
        REG_ITER_LIMIT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [CMP_WIDTH-1:0] const_real;
        logic signed [CMP_WIDTH-1:0] const_imag;
        logic signed [CMP_WIDTH-1:0] origin_real;
        logic signed [CMP_WIDTH-1:0] origin_imag;
        logic [STEP_WIDTH-1:0]       step_real;
        logic [STEP_WIDTH-1:0]       step_imag;
        logic [ITER_WIDTH-1:0]       iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic start;
        logic mul;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic escape;
        logic at_limit;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [CMP_WIDTH-1:0] sat32(
        input logic signed [PROD_WIDTH-1:0] v
    );
        logic signed [CMP_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[CMP_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[CMP_WIDTH-1:0];
        end else begin
            r = v[CMP_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/jet_cfg_regs.sv =====
module jet_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [jet_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output jet_pkg::t_cfg                        o_cfg
);
    import jet_pkg::*;

    localparam logic [CFG_DATA_WIDTH-1:0] ITER_MAX_CFG =
        CFG_DATA_WIDTH'({ITER_WIDTH{1'b1}});

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CONST_REAL:  n_cfg.const_real  = i_cfg_data[CMP_WIDTH-1:0];
                REG_CONST_IMAG:  n_cfg.const_imag  = i_cfg_data[CMP_WIDTH-1:0];
                REG_ORIGIN_REAL: n_cfg.origin_real = i_cfg_data[CMP_WIDTH-1:0];
                REG_ORIGIN_IMAG: n_cfg.origin_imag = i_cfg_data[CMP_WIDTH-1:0];
                REG_STEP_REAL:   n_cfg.step_real   = i_cfg_data[STEP_WIDTH-1:0];
                REG_STEP_IMAG:   n_cfg.step_imag   = i_cfg_data[STEP_WIDTH-1:0];
                REG_ITER_LIMIT: begin
                    if (i_cfg_data > ITER_MAX_CFG) begin
                        n_cfg.iteration_limit = {ITER_WIDTH{1'b1}};
                    end else begin
                        n_cfg.iteration_limit = i_cfg_data[ITER_WIDTH-1:0];
                    end
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.const_real      <= -CMP_WIDTH'(32'sd187904819);
            r_cfg.const_imag      <= CMP_WIDTH'(32'sd72517838);
            r_cfg.origin_real     <= -CMP_WIDTH'(32'sd268435456);
            r_cfg.origin_imag     <= -CMP_WIDTH'(32'sd268435456);
            r_cfg.step_real       <= STEP_WIDTH'(662258);
            r_cfg.step_imag       <= STEP_WIDTH'(524288);
            r_cfg.iteration_limit <= ITER_WIDTH'(128);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/jet_ctrl.sv =====
module jet_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jet_pkg::t_dp_status i_status,
    output jet_pkg::t_dp_cmd    o_cmd
);
    import jet_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                if (i_status.escape || i_status.at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/jet_dpath.sv =====
module jet_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jet_pkg::t_cfg                      i_cfg,
    input  jet_pkg::t_dp_cmd                   i_cmd,
    output jet_pkg::t_dp_status                o_status,
    input  logic [jet_pkg::COORD_WIDTH-1:0]    i_col,
    input  logic [jet_pkg::COORD_WIDTH-1:0]    i_row,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [jet_pkg::ITER_WIDTH-1:0]     o_count,
    output logic                               o_escaped
);
    import jet_pkg::*;

    logic [MAP_WIDTH-1:0]           r_map_re;
    logic [MAP_WIDTH-1:0]           r_map_im;
    logic signed [CMP_WIDTH-1:0]    r_zr;
    logic signed [CMP_WIDTH-1:0]    r_zi;
    logic signed [PROD_WIDTH-1:0]   r_rr;
    logic signed [PROD_WIDTH-1:0]   r_ii;
    logic signed [PROD_WIDTH-1:0]   r_ri;
    logic [ITER_WIDTH-1:0]          r_k;
    logic                           r_out_valid;
    logic [ITER_WIDTH-1:0]          r_out_count;
    logic                           r_out_esc;

    logic signed [PROD_WIDTH-1:0]   w_rr;
    logic signed [PROD_WIDTH-1:0]   w_ii;
    logic signed [PROD_WIDTH-1:0]   w_ri;
    logic signed [PROD_WIDTH-1:0]   w_start_re;
    logic signed [PROD_WIDTH-1:0]   w_start_im;
    logic signed [PROD_WIDTH-1:0]   w_next_re;
    logic signed [PROD_WIDTH-1:0]   w_next_im;
    logic [PROD_WIDTH-1:0]          w_mag;
    logic                           w_escape;

    assign w_rr = r_zr * r_zr;
    assign w_ii = r_zi * r_zi;
    assign w_ri = r_zr * r_zi;

    assign w_start_re = PROD_WIDTH'(i_cfg.origin_real) + $signed(PROD_WIDTH'(r_map_re));
    assign w_start_im = PROD_WIDTH'(i_cfg.origin_imag) + $signed(PROD_WIDTH'(r_map_im));

    assign w_next_re = ((r_rr - r_ii) >>> FRAC_BITS) + PROD_WIDTH'(i_cfg.const_real);
    assign w_next_im = (r_ri >>> (FRAC_BITS - 1)) + PROD_WIDTH'(i_cfg.const_imag);

    assign w_mag    = $unsigned(r_rr) + $unsigned(r_ii);
    assign w_escape = ESC_ON && (r_k != '0) && (w_mag > ESC_LIMIT);

    assign o_status.escape   = w_escape;
    assign o_status.at_limit = (r_k == i_cfg.iteration_limit);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_count     = r_out_count;
    assign o_escaped   = r_out_esc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_map_re <= MAP_WIDTH'(i_col) * MAP_WIDTH'(i_cfg.step_real);
            r_map_im <= MAP_WIDTH'(i_row) * MAP_WIDTH'(i_cfg.step_imag);
        end
        if (i_cmd.start) begin
            r_zr <= sat32(w_start_re);
            r_zi <= sat32(w_start_im);
            r_k  <= '0;
        end else if (i_cmd.step) begin
            r_zr <= sat32(w_next_re);
            r_zi <= sat32(w_next_im);
            r_k  <= r_k + ITER_WIDTH'(1);
        end
        if (i_cmd.mul) begin
            r_rr <= w_rr;
            r_ii <= w_ii;
            r_ri <= w_ri;
        end
        if (i_cmd.emit) begin
            r_out_esc   <= w_escape;
            r_out_count <= w_escape ? r_k - ITER_WIDTH'(1) : r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/julia_escape_time_pixel.sv =====
// Julia set escape-time evaluator for one pixel. Each item carries a pixel column and row;
// the block maps them to a start point origin + coordinate * step, then iterates
// z = z*z + c in signed Q4.28 until the squared magnitude exceeds 4 or the iteration
// limit is reached. Each iteration goes through the shared multiply and update loop: the
// multiply state uses three 32 by 32 multipliers, then the update state does the update and
// escape test. After acceptance an item passes through a start state, then alternates
// between the multiply and update states until it stops; the escape is seen one multiply after the
// escaping iteration. A new item is accepted once the previous result has been placed in
// the output register, so a result that is still waiting there holds the finished item
// back and stalls the input. Configuration registers are written through the cfg channel;
// the user must write them only while the block is idle, as the block does not enforce it.
module julia_escape_time_pixel (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // pixel_col, pixel_row
    input  logic [jet_pkg::IN_TDATA_WIDTH-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // iter_count, hue, brightness, saturation
    output logic [jet_pkg::OUT_TDATA_WIDTH-1:0]     m_axis_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [jet_pkg::CFG_IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data
);
    import jet_pkg::*;

    t_cfg                  w_cfg;
    t_dp_cmd               w_cmd;
    t_dp_status            w_status;
    logic [ITER_WIDTH-1:0] w_count;
    logic                  w_escaped;

    jet_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    jet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jet_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_col       (s_axis_tdata[COORD_WIDTH-1:0]),
        .i_row       (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_count     (w_count),
        .o_escaped   (w_escaped)
    );

    assign m_axis_tdata = OUT_TDATA_WIDTH'({
        BYTE_FULL,
        (w_escaped ? BYTE_FULL : BYTE_ZERO),
        w_count[BYTE_WIDTH-1:0],
        w_count
    });

endmodule
